[rtl/fte_pkg.sv]
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types and constants of the binary indexed tree engine.
// ----------------------------------------------------------------------------
package fte_pkg;

   localparam int FIELD_W = 11;
   localparam int IDX_W   = 12;
   localparam int DATA_W  = 64;
   localparam int ACT_W   = 2;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SUM   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LOWER = 2'd2;

   localparam logic [CSR_AW-3:0]  REG_ENTRIES   = 1'b0;
   localparam logic [FIELD_W-1:0] ENTRIES_RESET = 11'd1024;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [FIELD_W-1:0] range_start;
      logic [FIELD_W-1:0] position;
      logic [DATA_W-1:0]  delta;
      logic [DATA_W-1:0]  target;
   } fte_req_type;

endpackage

[rtl/fte_ram.sv]
// ----------------------------------------------------------------------------
// fte_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fte_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/fte_csr.sv]
// ----------------------------------------------------------------------------
// fte_csr
// Register block: holds the entries-in-use register and its clamped count.
// ----------------------------------------------------------------------------
module fte_csr import fte_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic [IDX_W-1:0]  active_n
);

   logic [FIELD_W-1:0] entries_ff;
   logic [FIELD_W-1:0] entries_in;
   logic               hit;

   assign hit = (paddr[CSR_AW-1:2] == REG_ENTRIES);

   always_comb begin
      entries_in = entries_ff;
      if (psel && penable && pwrite && hit) begin
         entries_in = pwdata[FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
      end else begin
         entries_ff <= entries_in;
      end
   end

   assign prdata   = hit ? CSR_DW'(entries_ff) : '0;
   assign active_n = (32'(entries_ff) > DEPTH) ? IDX_W'(DEPTH) : IDX_W'(entries_ff);

endmodule

[rtl/fte_seq.sv]
// ----------------------------------------------------------------------------
// fte_seq
// Sequencer: clearing pass, tree walks over the cell RAM and result registers.
// ----------------------------------------------------------------------------
module fte_seq import fte_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  fte_req_type              req,
   input  logic [IDX_W-1:0]         active_n,
   output logic                     busy,
   output logic                     mem_we,
   output logic [$clog2(DEPTH)-1:0] mem_waddr,
   output logic [DATA_W-1:0]        mem_wdata,
   output logic [$clog2(DEPTH)-1:0] mem_raddr,
   input  logic [DATA_W-1:0]        mem_rdata,
   output logic                     rsp_valid,
   output logic [DATA_W-1:0]        rsp_sum_result,
   output logic [FIELD_W-1:0]       rsp_found_index
);

   localparam int AW = $clog2(DEPTH);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ADD_RD = 3'd2;
   localparam logic [2:0] S_ADD_WR = 3'd3;
   localparam logic [2:0] S_SUM_RD = 3'd4;
   localparam logic [2:0] S_SUM_AC = 3'd5;
   localparam logic [2:0] S_LB_RD  = 3'd6;
   localparam logic [2:0] S_LB_CHK = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic               phase_ff, phase_in;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  w_ff, w_in;
   logic               valid_ff, valid_in;
   logic [DATA_W-1:0]  sum_ff, sum_in;
   logic [FIELD_W-1:0] found_ff, found_in;

   logic [IDX_W-1:0]   pos_w, lo_w, nxt_add, probe, idx_step;

   function automatic logic [IDX_W-1:0] top_power(input logic [IDX_W-1:0] n);
      logic [IDX_W-1:0] p;
      p = IDX_W'(1);
      for (int b = 0; b < IDX_W; b++) begin
         if (n[b]) begin
            p = IDX_W'(1) << b;
         end
      end
      return p;
   endfunction

   assign pos_w    = IDX_W'(req.position);
   assign lo_w     = IDX_W'(req.range_start);
   assign nxt_add  = idx_ff | (idx_ff + IDX_W'(1));
   assign probe    = idx_ff + step_ff - IDX_W'(1);
   assign idx_step = idx_ff + step_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      idx_in    = idx_ff;
      lo_in     = lo_ff;
      step_in   = step_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      w_in      = w_ff;
      valid_in  = 1'b0;
      sum_in    = sum_ff;
      found_in  = found_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(idx_ff);
      mem_wdata = mem_rdata + w_ff;
      mem_raddr = AW'(idx_ff);
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req.action)
                  ACT_ADD: begin
                     if (pos_w < active_n) begin
                        idx_in   = pos_w;
                        w_in     = req.delta;
                        state_in = S_ADD_RD;
                     end
                  end
                  ACT_SUM: begin
                     idx_in   = (pos_w > active_n) ? active_n : pos_w;
                     lo_in    = (lo_w > active_n) ? active_n : lo_w;
                     acc_in   = '0;
                     phase_in = 1'b0;
                     state_in = S_SUM_RD;
                  end
                  ACT_LOWER: begin
                     if (req.target[DATA_W-1] || (req.target == '0)) begin
                        valid_in = 1'b1;
                        sum_in   = '0;
                        found_in = '0;
                     end else begin
                        idx_in   = '0;
                        step_in  = top_power(active_n);
                        w_in     = req.target;
                        state_in = S_LB_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            mem_we = 1'b1;
            if (nxt_add < active_n) begin
               idx_in   = nxt_add;
               state_in = S_ADD_RD;
            end else begin
               valid_in = 1'b1;
               sum_in   = '0;
               found_in = '0;
               state_in = S_IDLE;
            end
         end
         S_SUM_RD: begin
            mem_raddr = AW'(idx_ff - IDX_W'(1));
            if (idx_ff == '0) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  idx_in   = lo_ff;
               end else begin
                  valid_in = 1'b1;
                  sum_in   = acc_ff;
                  found_in = '0;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_SUM_AC;
            end
         end
         S_SUM_AC: begin
            acc_in   = phase_ff ? acc_ff - mem_rdata : acc_ff + mem_rdata;
            idx_in   = idx_ff & (idx_ff - IDX_W'(1));
            state_in = S_SUM_RD;
         end
         S_LB_RD: begin
            mem_raddr = AW'(probe);
            if (probe < active_n) begin
               state_in = S_LB_CHK;
            end else begin
               step_in = step_ff >> 1;
               if (step_ff == IDX_W'(1)) begin
                  valid_in = 1'b1;
                  sum_in   = '0;
                  found_in = FIELD_W'(idx_ff);
                  state_in = S_IDLE;
               end
            end
         end
         S_LB_CHK: begin
            if ($signed(mem_rdata) < $signed(w_ff)) begin
               w_in   = w_ff - mem_rdata;
               idx_in = idx_step;
            end
            step_in = step_ff >> 1;
            if (step_ff == IDX_W'(1)) begin
               valid_in = 1'b1;
               sum_in   = '0;
               found_in = FIELD_W'(idx_in);
               state_in = S_IDLE;
            end else begin
               state_in = S_LB_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         valid_ff <= valid_in;
      end
      idx_ff   <= idx_in;
      lo_ff    <= lo_in;
      step_ff  <= step_in;
      phase_ff <= phase_in;
      acc_ff   <= acc_in;
      w_ff     <= w_in;
      sum_ff   <= sum_in;
      found_ff <= found_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_sum_result  = sum_ff;
   assign rsp_found_index = found_ff;

`ifndef ASSERT_OFF
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("engine not busy during clearing pass");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while engine busy");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("cell write while idle");
   a_found_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (IDX_W'(rsp_found_index) <= active_n))
      else $error("search result beyond active entries");
`endif

endmodule

[rtl/fenwick_tree_engine.sv]
// ----------------------------------------------------------------------------
// fenwick_tree_engine
// Binary indexed tree over signed 64-bit cells held in one synchronous RAM.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken when busy is low, and busy stays
// high until the walk over the cell RAM is done. Each tree level is a RAM
// read, then a use or write back: an add walks the levels from position
// upward, a range sum one level per set bit of R and of L, and a lower-bound
// search probes once per power of two up to n, with the check skipped when
// the probe lies at or beyond n; a target of zero or less answers at once.
// Results appear on rsp_valid for exactly one cycle and cannot be
// held off; ignored transactions produce no strobe. After reset the RAM is
// cleared in a pass with busy high; register writes are still taken then.
module fenwick_tree_engine import fte_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACT_W-1:0]    req_action,
   input  logic [FIELD_W-1:0]  req_range_start,
   input  logic [FIELD_W-1:0]  req_position,
   input  logic signed [DATA_W-1:0] req_delta,
   input  logic signed [DATA_W-1:0] req_target,
   output logic                rsp_valid,
   output logic signed [DATA_W-1:0] rsp_sum_result,
   output logic [FIELD_W-1:0]  rsp_found_index,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready
);

   localparam int AW = $clog2(DEPTH);

   fte_req_type       req;
   logic [IDX_W-1:0]  active_n;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata, mem_rdata;
   logic [DATA_W-1:0] sum_raw;

   assign req.action      = req_action;
   assign req.range_start = req_range_start;
   assign req.position    = req_position;
   assign req.delta       = req_delta;
   assign req.target      = req_target;

   assign pready         = 1'b1;
   assign rsp_sum_result = $signed(sum_raw);

   fte_csr #(.DEPTH(DEPTH)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .active_n (active_n)
   );

   fte_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_cells (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   fte_seq #(.DEPTH(DEPTH)) u_seq (
      .clock           (clock),
      .reset           (reset),
      .accept          (start && !busy),
      .req             (req),
      .active_n        (active_n),
      .busy            (busy),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata),
      .rsp_valid       (rsp_valid),
      .rsp_sum_result  (sum_raw),
      .rsp_found_index (rsp_found_index)
   );

endmodule
